@@ hw/rtl/ptt_pkg.sv @@
// Shared types and constants for the periodic timer table.
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

	// Command codes carried on the opcode port.
	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_KILL = 2'd2
	} op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// One table entry as stored in the entry memory.
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] period;
		logic [31:0] count;
	} entry_t;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Register map and register reset values.
	localparam int          ADDR_W          = 3;
	localparam int          REG_TICK_STEP   = 0;
	localparam int          STEP_W          = 10;
	localparam logic [9:0]  TICK_STEP_RESET = 10'd50;

	// Most expiry beats reported for a single tick.
	localparam int MAX_RESULTS = 16;

endpackage : ptt_pkg

`default_nettype wire

@@ hw/rtl/periodic_timer_table.sv @@
// Top level of the periodic timer table: sequencer, entry memory and register port.
//
//  Channel   Signals                                      Handshake
//  --------  -------------------------------------------  -------------------------------
//  command   start, busy, opcode, timer_id, period        beat taken when start && !busy
//  result    result_valid, kind, success, fired_id, last  one-cycle strobe, no back-pressure
//  config    psel, penable, pwrite, paddr, pwdata,        APB, pready always high
//            prdata, pready
//
// Every tick, set or kill keeps busy high while the sequencer walks the entry memory one
// slot per cycle through its single read port, then evaluates the last slot, sees the read
// pipeline empty and finishes. Each expiry beat is held until the next slot fires, so beats
// leave during the walk, and the final beat of a command appears in the first cycle with
// busy low.
// An unused opcode is taken and dropped with busy staying low.
// Reset clears the valid bits, the sequencer and tick_step (to 50); the memory needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_table #(
	parameter int NUM_TIMERS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// Command channel.
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  opcode,
	input  wire logic [31:0]                 timer_id,
	input  wire logic [31:0]                 period,
	// Result channel.
	output logic                             result_valid,
	output logic                             kind,
	output logic                             success,
	output logic [31:0]                      fired_id,
	output logic                             last,
	// Configuration port.
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ptt_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int RES_W = $clog2(ptt_pkg::MAX_RESULTS + 1);
	localparam int ENT_W = $bits(ptt_pkg::entry_t);

	ptt_pkg::state_t state_q, state_d;

	ptt_pkg::op_t                 op_q;
	logic [31:0]                  id_q;
	logic [31:0]                  period_q;
	logic [ptt_pkg::STEP_W-1:0]   tick_step_q;
	logic [NUM_TIMERS-1:0]        valid_q;
	logic [CNT_W-1:0]             rd_cnt_q;
	logic                         vld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic                         found_q;
	logic [IDX_W-1:0]             slot_q;
	logic                         pend_q;
	logic [31:0]                  pend_id_q;
	logic [RES_W-1:0]             n_q;

	logic                         result_valid_q;
	logic                         kind_q;
	logic                         success_q;
	logic [31:0]                  fired_id_q;
	logic                         last_q;

	logic                         op_known;
	logic                         accept;
	logic                         rd_issue;
	logic [ENT_W-1:0]             ram_rdata;
	ptt_pkg::entry_t              ent;
	logic                         hit_valid;
	logic [32:0]                  sum;
	logic [31:0]                  cnt_sat;
	logic                         fire;
	logic [31:0]                  new_cnt;
	logic                         tick_we;
	logic                         id_match;
	logic [IDX_W-1:0]             free_idx;
	logic                         free_any;
	logic [IDX_W-1:0]             set_slot;
	logic                         set_ok;
	logic                         finish_set;
	logic                         ram_we;
	logic [IDX_W-1:0]             ram_waddr;
	ptt_pkg::entry_t              ram_wdata;
	logic                         cfg_wr;
	logic                         cfg_hit;

	// Command decode; the unused opcode is accepted but starts nothing.
	assign op_known = (opcode == ptt_pkg::OP_TICK) || (opcode == ptt_pkg::OP_SET) ||
		(opcode == ptt_pkg::OP_KILL);
	assign busy     = (state_q != ptt_pkg::ST_IDLE);
	assign accept   = start && !busy && op_known;
	assign rd_issue = (state_q == ptt_pkg::ST_SCAN) && (rd_cnt_q != CNT_W'(NUM_TIMERS));

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: walk all slots, drain the evaluate stage, then finish.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (accept) state_d = ptt_pkg::ST_SCAN;
			end
			ptt_pkg::ST_SCAN: begin
				if (!rd_issue && !vld_s1) state_d = ptt_pkg::ST_FINISH;
			end
			ptt_pkg::ST_FINISH: begin
				state_d = ptt_pkg::ST_IDLE;
			end
			default: begin
				state_d = ptt_pkg::ST_IDLE;
			end
		endcase
	end

	// Entry memory holding id, period and count of each slot.
	ptt_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_TIMERS),
		.AW    (IDX_W)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (rd_issue),
		.raddr (rd_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Evaluate stage: saturating count update and expiry check.
	assign ent       = ptt_pkg::entry_t'(ram_rdata);
	assign hit_valid = vld_s1 && valid_q[idx_s1];
	assign sum       = {1'b0, ent.count} + {{(33 - ptt_pkg::STEP_W){1'b0}}, tick_step_q};
	assign cnt_sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign fire      = (cnt_sat >= ent.period);
	assign new_cnt   = fire ? 32'd0 : cnt_sat;
	assign tick_we   = hit_valid && (op_q == ptt_pkg::OP_TICK);
	assign id_match  = hit_valid && (op_q != ptt_pkg::OP_TICK) && (ent.id == id_q) && !found_q;

	// Lowest free slot from the valid bits.
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
				free_any = 1'b1;
			end
		end
	end

	assign set_slot   = found_q ? slot_q : free_idx;
	assign set_ok     = found_q || free_any;
	assign finish_set = (state_q == ptt_pkg::ST_FINISH) && (op_q == ptt_pkg::OP_SET) && set_ok;

	// Write port: count write-back during a tick, new entry at the end of a set.
	always_comb begin
		ram_we    = tick_we || finish_set;
		ram_waddr = tick_we ? idx_s1 : set_slot;
		if (tick_we) begin
			ram_wdata.id     = ent.id;
			ram_wdata.period = ent.period;
			ram_wdata.count  = new_cnt;
		end else begin
			ram_wdata.id     = id_q;
			ram_wdata.period = period_q;
			ram_wdata.count  = 32'd0;
		end
	end

	// Read pipeline and match flag, cleared when a command is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
			if (accept) begin
				rd_cnt_q <= '0;
				found_q  <= 1'b0;
			end else begin
				if (rd_issue) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				if (id_match) found_q <= 1'b1;
			end
		end
	end

	// Payload registers of the command and the pipeline.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= ptt_pkg::op_t'(opcode);
			id_q     <= timer_id;
			period_q <= period;
		end
		idx_s1 <= rd_cnt_q[IDX_W-1:0];
		if (id_match) slot_q <= idx_s1;
	end

	// Valid bits, updated when a set or kill finishes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (finish_set) begin
			valid_q[set_slot] <= 1'b1;
		end else if ((state_q == ptt_pkg::ST_FINISH) && (op_q == ptt_pkg::OP_KILL) &&
				found_q) begin
			valid_q[slot_q] <= 1'b0;
		end
	end

	// Result control: one expiry is held back so the final beat can carry last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pend_q         <= 1'b0;
			n_q            <= '0;
		end else begin
			result_valid_q <= 1'b0;
			if (accept) begin
				pend_q <= 1'b0;
				n_q    <= '0;
			end else if (tick_we && fire && (n_q < RES_W'(ptt_pkg::MAX_RESULTS))) begin
				result_valid_q <= pend_q;
				pend_q         <= 1'b1;
				n_q            <= n_q + RES_W'(1);
			end else if (state_q == ptt_pkg::ST_FINISH) begin
				result_valid_q <= (op_q != ptt_pkg::OP_TICK) || pend_q;
				pend_q         <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (tick_we && fire && (n_q < RES_W'(ptt_pkg::MAX_RESULTS))) begin
			pend_id_q  <= ent.id;
			kind_q     <= ptt_pkg::KIND_EXPIRY;
			success_q  <= 1'b0;
			fired_id_q <= pend_id_q;
			last_q     <= 1'b0;
		end else if (state_q == ptt_pkg::ST_FINISH) begin
			last_q <= 1'b1;
			if (op_q == ptt_pkg::OP_TICK) begin
				kind_q     <= ptt_pkg::KIND_EXPIRY;
				success_q  <= 1'b0;
				fired_id_q <= pend_id_q;
			end else begin
				kind_q     <= ptt_pkg::KIND_STATUS;
				success_q  <= (op_q == ptt_pkg::OP_SET) ? set_ok : found_q;
				fired_id_q <= 32'd0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = kind_q;
	assign success      = success_q;
	assign fired_id     = fired_id_q;
	assign last         = last_q;

	// Configuration register.
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = (paddr[ptt_pkg::ADDR_W-1] == 1'(ptt_pkg::REG_TICK_STEP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= ptt_pkg::TICK_STEP_RESET;
		end else if (cfg_wr && cfg_hit) begin
			tick_step_q <= pwdata[ptt_pkg::STEP_W-1:0];
		end
	end

	assign prdata = cfg_hit ? {{(32 - ptt_pkg::STEP_W){1'b0}}, tick_step_q} : 32'd0;
	assign pready = 1'b1;

endmodule : periodic_timer_table

`default_nettype wire

@@ hw/rtl/ptt_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ptt_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, updated only when re is high.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : ptt_ram

`default_nettype wire

@@ test/periodic_timer_table_tb.sv @@
// Self-checking testbench for the periodic timer table: command, result and register ports.
`timescale 1ns / 1ps

module periodic_timer_table_tb;

	localparam int NUM_TIMERS    = 16;
	localparam int SETTLE_CYCLES = NUM_TIMERS + 8;
	localparam int POOL_SIZE     = 12;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [ptt_pkg::ADDR_W-1:0] STEP_ADDR     =
		ptt_pkg::ADDR_W'(4 * ptt_pkg::REG_TICK_STEP);
	localparam logic [ptt_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
		ptt_pkg::ADDR_W'(4 * (ptt_pkg::REG_TICK_STEP + 1));

	// One result beat as seen on the result ports.
	typedef struct packed {
		logic        kind;
		logic        success;
		logic [31:0] fired_id;
		logic        last;
	} beat_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [1:0]                  opcode;
	logic [31:0]                 timer_id;
	logic [31:0]                 period;
	logic                        result_valid;
	logic                        kind;
	logic                        success;
	logic [31:0]                 fired_id;
	logic                        last;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [ptt_pkg::ADDR_W-1:0]  paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;

	// Shadow copy of the timer table and the tick step.
	logic                        tbl_valid  [NUM_TIMERS];
	logic [31:0]                 tbl_id     [NUM_TIMERS];
	logic [31:0]                 tbl_period [NUM_TIMERS];
	logic [31:0]                 tbl_count  [NUM_TIMERS];
	logic [ptt_pkg::STEP_W-1:0]  step_now;

	beat_t       expected_beats[$];
	logic [31:0] id_pool [POOL_SIZE];
	bit          gaps_on;
	int          mismatch_count;
	int          n_ticks, n_sets, n_kills, n_unused;
	int          n_status_beats, n_expiry_beats;

	periodic_timer_table #(
		.NUM_TIMERS(NUM_TIMERS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.timer_id    (timer_id),
		.period      (period),
		.result_valid(result_valid),
		.kind        (kind),
		.success     (success),
		.fired_id    (fired_id),
		.last        (last),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// Free-running 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Updates the shadow table for one accepted command and queues the beats it causes.
	function automatic void predict_command(input logic [1:0] op, input logic [31:0] id,
			input logic [31:0] per);
		int          slot;
		logic [32:0] sum;
		logic [31:0] cnt;
		beat_t       fired[$];
		beat_t       b;
		slot = -1;
		if (op == ptt_pkg::OP_TICK) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (tbl_valid[i]) begin
					sum = {1'b0, tbl_count[i]} + {23'd0, step_now};
					cnt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
					if (cnt >= tbl_period[i]) begin
						cnt = 32'd0;
						if (fired.size() < ptt_pkg::MAX_RESULTS) begin
							b = '{ptt_pkg::KIND_EXPIRY, 1'b0, tbl_id[i], 1'b0};
							fired.push_back(b);
						end
					end
					tbl_count[i] = cnt;
				end
			end
			if (fired.size() > 0) begin
				fired[fired.size() - 1].last = 1'b1;
			end
			foreach (fired[k]) begin
				expected_beats.push_back(fired[k]);
			end
		end else if (op == ptt_pkg::OP_SET || op == ptt_pkg::OP_KILL) begin
			// Only valid entries take part in the match; the lowest slot wins.
			for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
				if (tbl_valid[i] && tbl_id[i] == id) begin
					slot = i;
				end
			end
			if (op == ptt_pkg::OP_SET && slot < 0) begin
				for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
					if (!tbl_valid[i]) begin
						slot = i;
					end
				end
			end
			if (slot >= 0) begin
				tbl_valid[slot]  = (op == ptt_pkg::OP_SET);
				tbl_id[slot]     = (op == ptt_pkg::OP_SET) ? id : 32'd0;
				tbl_period[slot] = (op == ptt_pkg::OP_SET) ? per : 32'd0;
				tbl_count[slot]  = 32'd0;
			end
			b = '{ptt_pkg::KIND_STATUS, slot >= 0, 32'd0, 1'b1};
			expected_beats.push_back(b);
		end
	endfunction

	// Sends one command beat; a random gap starts once the previous command has finished.
	task automatic issue_command(input logic [1:0] op, input logic [31:0] id,
			input logic [31:0] per);
		int gap;
		if (gaps_on && $urandom_range(0, 99) < 26) begin
			gap = $urandom_range(1, 24);
			start <= 1'b0;
			@(posedge clk);
			while (busy) @(posedge clk);
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		opcode   <= op;
		timer_id <= id;
		period   <= per;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(op, id, per);
		case (op)
			ptt_pkg::OP_TICK: n_ticks++;
			ptt_pkg::OP_SET:  n_sets++;
			ptt_pkg::OP_KILL: n_kills++;
			default:          n_unused++;
		endcase
	endtask

	// Lets every queued beat arrive, then waits out a possible silent tick walk.
	task automatic drain_and_settle();
		start <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ptt_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == STEP_ADDR) begin
			step_now = data[ptt_pkg::STEP_W-1:0];
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reads the tick step register back and compares it with the shadow value.
	task automatic check_step_reg();
		logic [31:0] want;
		want    = {22'd0, step_now};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= STEP_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$display("%0t: tick_step readback mismatch: expected %h, got %h", $time, want, prdata);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Every result beat is compared with the oldest queued one.
	always @(posedge clk) begin : result_check
		beat_t got;
		beat_t want;
		if (arst_n && result_valid) begin
			got = '{kind, success, fired_id, last};
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected result beat: got kind=%0d success=%0d id=%h last=%0d",
					$time, got.kind, got.success, got.fired_id, got.last);
				mismatch_count++;
			end else begin
				want = expected_beats.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch: expected kind=%0d success=%0d id=%h ",
						"last=%0d, got kind=%0d success=%0d id=%h last=%0d",
						$time, want.kind, want.success, want.fired_id, want.last,
						got.kind, got.success, got.fired_id, got.last);
					mismatch_count++;
				end
				if (want.kind == ptt_pkg::KIND_EXPIRY) begin
					n_expiry_beats++;
				end else begin
					n_status_beats++;
				end
			end
		end
	end

	// Empty table after reset: reset step, silent tick, failed kill, dropped opcode.
	task automatic test_reset_state();
		check_step_reg();
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'd5, 32'd0);
		issue_command(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// Extreme ids and periods, updates of an existing timer, zero period, kills.
	task automatic test_set_kill_extremes();
		issue_command(ptt_pkg::OP_SET, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(ptt_pkg::OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue_command(ptt_pkg::OP_SET, 32'hFFFF_FFFF, 32'd100);
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'hFFFF_FFFF, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'hFFFF_FFFF, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'd0, 32'd0);
	endtask

	// Freed slots never match, and expiries leave in slot order rather than set order.
	task automatic test_duplicate_match();
		issue_command(ptt_pkg::OP_SET, 32'hA5A5_0001, 32'd0);
		issue_command(ptt_pkg::OP_SET, 32'h5A5A_0002, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'hA5A5_0001, 32'd0);
		issue_command(ptt_pkg::OP_SET, 32'h5A5A_0002, 32'd0);
		issue_command(ptt_pkg::OP_SET, 32'h0000_0C0C, 32'd0);
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'h5A5A_0002, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'h0000_0C0C, 32'd0);
	endtask

	// Step of zero, the largest masked step, and a write to an unmapped address.
	task automatic test_step_extremes();
		drain_and_settle();
		apb_write(STEP_ADDR, 32'd0);
		check_step_reg();
		issue_command(ptt_pkg::OP_SET, 32'd10, 32'd0);
		issue_command(ptt_pkg::OP_SET, 32'd11, 32'd5);
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		drain_and_settle();
		apb_write(STEP_ADDR, 32'hFFFF_FFFF);
		apb_write(UNMAPPED_ADDR, 32'd7);
		check_step_reg();
		issue_command(ptt_pkg::OP_TICK, 32'd0, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'd10, 32'd0);
		issue_command(ptt_pkg::OP_KILL, 32'd11, 32'd0);
	endtask

	// Fills every free slot, tries one set too many, ticks, then kills everything.
	task automatic test_table_full();
		int          free_slots;
		logic [31:0] per;
		free_slots = 0;
		foreach (tbl_valid[i]) begin
			if (!tbl_valid[i]) begin
				free_slots++;
			end
		end
		for (int i = 0; i < free_slots; i++) begin
			per = ($urandom_range(0, 1) == 0) ? 32'd0 :
				32'(step_now) * 32'($urandom_range(1, 3));
			issue_command(ptt_pkg::OP_SET, $urandom(), per);
		end
		issue_command(ptt_pkg::OP_SET, $urandom(), $urandom());
		repeat (3) issue_command(ptt_pkg::OP_TICK, $urandom(), $urandom());
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (tbl_valid[i]) begin
				issue_command(ptt_pkg::OP_KILL, tbl_id[i], $urandom());
			end
		end
	endtask

	// Random commands over a small id pool so that sets, kills and expiries interact.
	task automatic test_random_traffic(input int n_items, input logic [31:0] step_word,
			input bit idle_gaps);
		int          r;
		int          valid_slots[$];
		logic [1:0]  op;
		logic [31:0] id;
		logic [31:0] per;
		drain_and_settle();
		apb_write(STEP_ADDR, step_word);
		check_step_reg();
		gaps_on = idle_gaps;
		for (int k = 0; k < n_items; k++) begin
			r  = $urandom_range(0, 99);
			op = (r < 38) ? ptt_pkg::OP_TICK : (r < 72) ? ptt_pkg::OP_SET :
				(r < 95) ? ptt_pkg::OP_KILL : OP_UNUSED;
			id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)] :
				$urandom();
			// Kills mostly aim at a live timer.
			if (op == ptt_pkg::OP_KILL && $urandom_range(0, 99) < 70) begin
				valid_slots.delete();
				foreach (tbl_valid[i]) begin
					if (tbl_valid[i]) begin
						valid_slots.push_back(i);
					end
				end
				if (valid_slots.size() > 0) begin
					id = tbl_id[valid_slots[$urandom_range(0, valid_slots.size() - 1)]];
				end
			end
			r = $urandom_range(0, 99);
			if (r < 70) begin
				per = 32'(step_now) * 32'($urandom_range(0, 6)) +
					$urandom_range(0, 32'(step_now));
			end else if (r < 90) begin
				per = $urandom_range(0, 3);
			end else begin
				per = $urandom();
			end
			issue_command(op, id, per);
		end
		gaps_on = 1'b1;
	endtask

	// Run limit.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Reset, then each test in turn.
	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		opcode   = ptt_pkg::OP_TICK;
		timer_id = 32'd0;
		period   = 32'd0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = 32'd0;
		step_now = ptt_pkg::TICK_STEP_RESET;
		gaps_on  = 1'b1;
		mismatch_count = 0;
		n_ticks = 0;
		n_sets = 0;
		n_kills = 0;
		n_unused = 0;
		n_status_beats = 0;
		n_expiry_beats = 0;
		foreach (tbl_valid[i]) begin
			tbl_valid[i]  = 1'b0;
			tbl_id[i]     = 32'd0;
			tbl_period[i] = 32'd0;
			tbl_count[i]  = 32'd0;
		end
		id_pool[0] = 32'd0;
		id_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			id_pool[i] = $urandom();
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_set_kill_extremes();
		test_duplicate_match();
		test_step_extremes();
		test_random_traffic(60, 32'd1, 1'b1);
		test_table_full();
		test_random_traffic(60, 32'd1000, 1'b1);
		test_random_traffic(60, $urandom_range(1, 1000), 1'b0);
		test_table_full();
		test_random_traffic(50, 32'hABCD_E3FF, 1'b1);
		test_random_traffic(20, 32'd0, 1'b1);
		drain_and_settle();

		$display("Covered %0d ticks, %0d sets, %0d kills and %0d unused commands; ",
			"checked %0d status and %0d expiry beats.",
			n_ticks, n_sets, n_kills, n_unused, n_status_beats, n_expiry_beats);
		$display("Tick steps of 0, 1, 50, 1000, 1023 and a random value; table filled to capacity twice.");
		if (mismatch_count == 0 && expected_beats.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ periodic_timer_table.f @@
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/periodic_timer_table.sv
test/periodic_timer_table_tb.sv
